[hdl/dlb_pkg.sv]
// ----------------------------------------------------------------------------
// dlb_pkg
// Shared types and constants of the cyclic DMA descriptor list builder.
// ----------------------------------------------------------------------------
package dlb_pkg;

    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 32;
    localparam int BYTES_W     = 13;
    localparam int IDX_W       = 8;
    localparam int OFF_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;

    localparam int DEFAULT_MAX_ENTRIES = 256;

    // chunks never cross this boundary of the buffer offset
    localparam logic [BYTES_W-1:0] BOUNDARY = 13'h1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_BUFFER_BYTES = 2'd1,
        CFG_PERIOD_SIZE  = 2'd2,
        CFG_WAKEUP_EN    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_LIMIT = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [LEN_W-1:0]  buffer_bytes;
        logic [LEN_W-1:0]  period_size;
        logic              wakeup_en;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  entry_address;
        logic [BYTES_W-1:0] entry_bytes;
        logic               interrupt_on_completion;
        logic [IDX_W-1:0]   entry_index;
        logic               last_entry;
        t_status            status;
    } t_entry;

endpackage

[hdl/dlb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dlb_cfg_regs
// Configuration register file: base address, buffer and period size, wakeup.
// ----------------------------------------------------------------------------
module dlb_cfg_regs
    import dlb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= '0;
            r_cfg.buffer_bytes <= '0;
            r_cfg.period_size  <= '0;
            r_cfg.wakeup_en    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_ADDRESS: r_cfg.base_address <= i_cfg_wdata;
                CFG_BUFFER_BYTES: r_cfg.buffer_bytes <= i_cfg_wdata[LEN_W-1:0];
                CFG_PERIOD_SIZE:  r_cfg.period_size  <= i_cfg_wdata[LEN_W-1:0];
                CFG_WAKEUP_EN:    r_cfg.wakeup_en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/dlb_engine.sv]
// ----------------------------------------------------------------------------
// dlb_engine
// List walk state and the single-pass logic that cuts the next chunk.
// ----------------------------------------------------------------------------
module dlb_engine
    import dlb_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  logic   i_restart,
    input  t_cfg   i_cfg,
    output t_entry o_entry
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    logic [LEN_W-1:0] r_offset, n_offset;
    logic [LEN_W-1:0] r_buf_left, n_buf_left;
    logic [LEN_W-1:0] r_per_left, n_per_left;
    logic             r_per_full, n_per_full;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_stopped, n_stopped;

    // state as seen after an optional restart
    logic [LEN_W-1:0]   s_offset, s_buf_left, s_per_left;
    logic               s_per_full, s_stopped;
    logic [CNT_W-1:0]   s_count;
    logic [LEN_W-1:0]   per_size, per_left, per_after, buf_after;
    logic               per_full;
    logic [BYTES_W-1:0] room, chunk;
    logic               last;

    always_comb begin
        s_offset   = i_restart ? '0 : r_offset;
        s_buf_left = i_restart ? i_cfg.buffer_bytes : r_buf_left;
        s_per_left = i_restart ? '0 : r_per_left;
        s_per_full = i_restart ? 1'b0 : r_per_full;
        s_count    = i_restart ? '0 : r_count;
        s_stopped  = i_restart ? (i_cfg.buffer_bytes == '0) : r_stopped;

        // open a new period when the current one is used up
        per_size = (i_cfg.period_size != '0) ? i_cfg.period_size : i_cfg.buffer_bytes;
        if (s_per_left != '0) begin
            per_left = s_per_left;
            per_full = s_per_full;
        end else if (per_size != '0 && s_buf_left >= per_size) begin
            per_left = per_size;
            per_full = 1'b1;
        end else begin
            per_left = s_buf_left;
            per_full = 1'b0;
        end

        room      = BOUNDARY - {1'b0, s_offset[OFF_W-1:0]};
        chunk     = (per_left < LEN_W'(room)) ? per_left[BYTES_W-1:0] : room;
        per_after = per_left - LEN_W'(chunk);
        buf_after = s_buf_left - LEN_W'(chunk);
        last      = (buf_after == '0);

        n_offset   = s_offset;
        n_buf_left = s_buf_left;
        n_per_left = s_per_left;
        n_per_full = s_per_full;
        n_count    = s_count;
        n_stopped  = s_stopped;
        o_entry    = '0;

        priority if (s_stopped) begin
            o_entry.status = ST_NONE;
        end else if (s_count >= MAX_CNT) begin
            n_stopped      = 1'b1;
            o_entry.status = ST_LIMIT;
        end else begin
            n_offset   = s_offset + LEN_W'(chunk);
            n_buf_left = buf_after;
            n_per_left = per_after;
            n_per_full = per_full;
            n_count    = s_count + 1'b1;
            n_stopped  = last;

            o_entry.entry_address = i_cfg.base_address + ADDR_W'(s_offset);
            o_entry.entry_bytes   = chunk;
            o_entry.interrupt_on_completion =
                (per_after == '0) && per_full && i_cfg.wakeup_en;
            o_entry.entry_index   = IDX_W'(s_count);
            o_entry.last_entry    = last;
            o_entry.status        = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_buf_left <= '0;
            r_per_left <= '0;
            r_per_full <= 1'b0;
            r_count    <= '0;
            r_stopped  <= 1'b1;
        end else if (i_push) begin
            r_offset   <= n_offset;
            r_buf_left <= n_buf_left;
            r_per_left <= n_per_left;
            r_per_full <= n_per_full;
            r_count    <= n_count;
            r_stopped  <= n_stopped;
        end
    end

endmodule

[hdl/dlb_skid.sv]
// ----------------------------------------------------------------------------
// dlb_skid
// Result register with a skid stage so the input ready stays registered.
// ----------------------------------------------------------------------------
module dlb_skid
    import dlb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    output logic   o_valid,
    input  logic   i_pop_ready,
    output t_entry o_entry
);

    logic   r_main_valid, r_skid_valid;
    t_entry r_main, r_skid;
    logic   pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_entry = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid word into the output register
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_entry;
            end else begin
                r_skid <= i_entry;
            end
        end
    end

endmodule

[hdl/dma_descriptor_list_builder_unit.sv]
// ----------------------------------------------------------------------------
// dma_descriptor_list_builder_unit
// Emits the descriptor entries of a cyclic DMA buffer, one per request word.
// ----------------------------------------------------------------------------
// Usage:
//   Program base address, buffer size, period size and wakeup through the
//   write port while idle. Each word on the s_axis side is a request: bit 0
//   set restarts the list and yields its first entry, clear yields the next.
//   Every request gives exactly one word on the m_axis side: tdata carries
//   the entry, tlast marks the entry holding the final buffer bytes and
//   tuser the status (valid, entry limit hit, nothing left).
// Timing:
//   An accepted request's entry goes into the result register, or into the skid
//   stage while the result register holds a stalled word. One request per cycle
//   is taken back to back while the skid stage is empty; the chunk cut, the state
//   update and 64-bit address add sit between the list state and result registers.
// Reset:
//   The list is stopped; requests answer "nothing left" until a restart.
// Stall:
//   A stalled receiver fills the result register and then the skid stage;
//   s_axis_tready drops only once both hold a word.
// ----------------------------------------------------------------------------
module dma_descriptor_list_builder_unit
    import dlb_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    // entry stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [63:0] entry_address,
                                                   // [76:64] entry_bytes,
                                                   // [77] interrupt_on_completion,
                                                   // [85:78] entry_index, [87:86] zero
    output logic                   m_axis_tlast,   // last_entry
    output logic [1:0]             m_axis_tuser    // [1:0] status
);

    t_cfg   cfg;
    t_entry step_entry, out_entry;
    logic   push;

    assign push = s_axis_tvalid && s_axis_tready;

    dlb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dlb_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_restart (s_axis_tdata[0]),
        .i_cfg     (cfg),
        .o_entry   (step_entry)
    );

    dlb_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (step_entry),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_entry     (out_entry)
    );

    assign m_axis_tdata = {2'b00, out_entry.entry_index, out_entry.interrupt_on_completion,
                           out_entry.entry_bytes, out_entry.entry_address};
    assign m_axis_tlast = out_entry.last_entry;
    assign m_axis_tuser = out_entry.status;

endmodule

[hdl/dlb_checker.sv]
// ----------------------------------------------------------------------------
// dlb_checker
// Port-level checks of the descriptor list builder, bound to the top level.
// ----------------------------------------------------------------------------
module dlb_checker
    import dlb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    input  logic [1:0]             m_axis_tuser
);

    // hold a stalled output word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("buffers not empty after reset");

    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_VALID |->
            m_axis_tdata == '0 && !m_axis_tlast)
        else $error("error word carries entry fields");

    a_chunk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_VALID |->
            m_axis_tdata[76:64] != '0 && m_axis_tdata[76:64] <= BOUNDARY)
        else $error("chunk length out of range");

    // input ready returns once the output side drains a word
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input ready stuck with output draining");

endmodule

bind dma_descriptor_list_builder_unit dlb_checker u_dlb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/dma_descriptor_list_builder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dma_descriptor_list_builder_unit_tb
// Self-checking bench for the cyclic DMA descriptor list builder. A predictor
// tracks the list state (offset, bytes left, period left, entry count) and
// builds the expected entry for each accepted request. The monitor compares
// every entry word, field by field, in order. A short directed part hits the
// corner cases. Random phases then reprogram the registers, build lists
// (entry limit runs included) and add stray restarts. Random bursts and gaps
// on the request side run against a stalling entry receiver.
// ----------------------------------------------------------------------------
module dma_descriptor_list_builder_unit_tb;
    import dlb_pkg::*;

    localparam int LIST_LIMIT      = DEFAULT_MAX_ENTRIES;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 4;

    // entry word layout on m_axis_tdata
    localparam int BYTES_LSB = ADDR_W;
    localparam int IOC_BIT   = ADDR_W + BYTES_W;
    localparam int IDX_LSB   = IOC_BIT + 1;
    localparam int PAD_LSB   = IDX_LSB + IDX_W;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_BURSTY
    } t_rx_mode;

    class descriptor_list_predictor;
        logic [ADDR_W-1:0] base_address;
        logic [LEN_W-1:0]  buffer_bytes;
        logic [LEN_W-1:0]  period_size;
        logic              wakeup_en;

        logic [LEN_W-1:0]  byte_offset;
        logic [LEN_W-1:0]  buffer_left;
        logic [LEN_W-1:0]  period_left;
        logic              period_is_full;
        logic [8:0]        entry_count;
        logic              stopped;

        t_entry entries_due[$];
        int mismatches, entries_seen, ioc_seen, ends_seen, limit_stops, empty_answers;

        function new();
            base_address   = '0;
            buffer_bytes   = '0;
            period_size    = '0;
            wakeup_en      = 1'b1;
            byte_offset    = '0;
            buffer_left    = '0;
            period_left    = '0;
            period_is_full = 1'b0;
            entry_count    = '0;
            stopped        = 1'b1;
            mismatches     = 0;
            entries_seen   = 0;
            ioc_seen       = 0;
            ends_seen      = 0;
            limit_stops    = 0;
            empty_answers  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BASE_ADDRESS: base_address = value;
                CFG_BUFFER_BYTES: buffer_bytes = value[LEN_W-1:0];
                CFG_PERIOD_SIZE:  period_size  = value[LEN_W-1:0];
                CFG_WAKEUP_EN:    wakeup_en    = value[0];
                default: ;
            endcase
        endfunction

        // advance the list by one request and queue the entry it should give
        function void note_request(logic restart);
            t_entry           e;
            logic [LEN_W-1:0] span;
            logic [LEN_W-1:0] room;
            logic [LEN_W-1:0] chunk;
            e = '0;
            if (restart) begin
                byte_offset    = '0;
                buffer_left    = buffer_bytes;
                entry_count    = '0;
                period_left    = '0;
                period_is_full = 1'b0;
                stopped        = (buffer_bytes == 0);
            end
            if (stopped) begin
                e.status = ST_NONE;
            end else if (entry_count >= LIST_LIMIT) begin
                stopped  = 1'b1;
                e.status = ST_LIMIT;
            end else begin
                if (period_left == 0) begin
                    span           = (period_size != 0) ? period_size : buffer_bytes;
                    period_is_full = (span != 0) && (buffer_left >= span);
                    period_left    = period_is_full ? span : buffer_left;
                end
                // never cross a 4 KB boundary of the buffer offset
                room  = LEN_W'(BOUNDARY) - LEN_W'(byte_offset[OFF_W-1:0]);
                chunk = (period_left < room) ? period_left : room;
                period_left -= chunk;
                buffer_left -= chunk;
                e.entry_address           = base_address + ADDR_W'(byte_offset);
                e.entry_bytes             = chunk[BYTES_W-1:0];
                e.interrupt_on_completion = (period_left == 0) && period_is_full
                                            && wakeup_en;
                e.entry_index             = entry_count[IDX_W-1:0];
                e.last_entry              = (buffer_left == 0);
                e.status                  = ST_VALID;
                byte_offset += chunk;
                entry_count += 1'b1;
                if (e.last_entry) begin
                    stopped = 1'b1;
                end
            end
            entries_due.push_back(e);
        endfunction

        function void compare_field(string field, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_entry(logic [OUT_TDATA_W-1:0] tdata, logic tlast,
                                  logic [1:0] tuser);
            t_entry want;
            if (entries_due.size() == 0) begin
                $display("%0t ns: entry word with no request pending, actual %0h",
                         $time, tdata);
                mismatches++;
                return;
            end
            want = entries_due.pop_front();
            compare_field("entry_address", want.entry_address, tdata[ADDR_W-1:0]);
            compare_field("entry_bytes", want.entry_bytes, tdata[BYTES_LSB +: BYTES_W]);
            compare_field("interrupt_on_completion", want.interrupt_on_completion,
                          tdata[IOC_BIT]);
            compare_field("entry_index", want.entry_index, tdata[IDX_LSB +: IDX_W]);
            compare_field("tdata pad", '0, tdata[OUT_TDATA_W-1:PAD_LSB]);
            compare_field("last_entry", want.last_entry, tlast);
            compare_field("status", want.status, tuser);
            entries_seen++;
            ioc_seen      += want.interrupt_on_completion;
            ends_seen     += want.last_entry;
            limit_stops   += (want.status == ST_LIMIT);
            empty_answers += (want.status == ST_NONE);
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic [1:0]             m_axis_tuser;

    descriptor_list_predictor bdl_predictor = new();

    int          requests_sent = 0;
    int          burst_left    = 0;
    int unsigned cycle_count   = 0;

    dma_descriptor_list_builder_unit #(
        .MAX_ENTRIES (LIST_LIMIT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: run stuck, stopped after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        bdl_predictor.write_reg(idx, value);
    endtask

    // buffer size is left alone when continuing a list mid-way
    task automatic program_list(logic [ADDR_W-1:0] base, logic [LEN_W-1:0] buffer_len,
                                logic [LEN_W-1:0] period_len, logic wakeup,
                                bit set_buffer);
        write_reg(CFG_BASE_ADDRESS, base);
        if (set_buffer) begin
            write_reg(CFG_BUFFER_BYTES, CFG_DATA_W'(buffer_len));
        end
        write_reg(CFG_PERIOD_SIZE, CFG_DATA_W'(period_len));
        write_reg(CFG_WAKEUP_EN, CFG_DATA_W'(wakeup));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(logic restart);
        if (burst_left == 0) begin
            if (s_axis_tvalid) begin
                s_axis_tvalid <= 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(restart);
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        bdl_predictor.note_request(restart);
        requests_sent++;
    endtask

    task automatic request_run(int count, bit lead_restart, int noise_pct);
        if (lead_restart) begin
            send_request(1'b1);
        end
        repeat (count) send_request($urandom_range(0, 99) < noise_pct);
    endtask

    // hold off until every entry is back and the block is quiet
    task automatic drain_list();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
        end
        @(posedge i_clk);
        while (bdl_predictor.entries_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return '1;
            3:       return {32'hffff_ffff, 32'(-$urandom_range(1, 20000))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_period(logic [LEN_W-1:0] buffer_len);
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return '1;
            3:       return buffer_len + $urandom_range(1, 100);
            4, 5, 6: return $urandom_range(1, (buffer_len == 0 || buffer_len > 10000)
                                              ? 10000 : int'(buffer_len));
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // entry receiver: stall pattern changes every window
    initial begin : entry_sink
        t_rx_mode rx_mode;
        int       window_left;
        int       stall_left;
        int       tick;
        rx_mode     = RX_OPEN;
        window_left = 0;
        stall_left  = 0;
        tick        = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                bdl_predictor.check_entry(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            if (window_left == 0) begin
                rx_mode     = t_rx_mode'($urandom_range(0, 3));
                window_left = $urandom_range(16, 128);
            end
            window_left--;
            tick++;
            case (rx_mode)
                RX_OPEN:  m_axis_tready <= 1'b1;
                RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
                RX_THIRD: m_axis_tready <= (tick % 3 == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 12);
                        end
                    end
                end
            endcase
        end
    end

    initial begin : request_source
        int               phase;
        int               kind;
        int               random_start;
        logic [LEN_W-1:0] buffer_len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stopped after reset, then a restart on an empty buffer
        send_request(1'b0);
        send_request(1'b1);
        drain_list();
        // periods split at 4 KB boundaries, short final period, address wraps
        program_list(64'hffff_ffff_ffff_f000, 32'd10000, 32'd3000, 1'b1, 1'b1);
        request_run(6, 1'b1, 0);
        drain_list();
        // largest buffer as one full period, wakeup off
        program_list('0, '1, '1, 1'b0, 1'b1);
        request_run(2, 1'b1, 0);
        drain_list();
        // period longer than the buffer: no interrupt mark
        program_list(64'h1234_5678_9abc_def0, 32'd5000, 32'd9000, 1'b1, 1'b1);
        request_run(2, 1'b1, 0);
        drain_list();
        // period zero spans the buffer; back to back restarts
        program_list(64'h8000_0000_0000_0000, 32'd4096, '0, 1'b1, 1'b1);
        send_request(1'b1);
        send_request(1'b1);
        drain_list();
        // one byte buffer at the top address
        program_list('1, 32'd1, 32'd1, 1'b1, 1'b1);
        request_run(1, 1'b1, 0);
        drain_list();

        phase        = 0;
        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_REQUESTS) begin
            kind = (phase == 0) ? 1 : $urandom_range(0, 9);
            case (kind)
                0: begin
                    program_list(pick_base(), '0, pick_period('0),
                                 1'($urandom_range(0, 1)), 1'b1);
                    request_run($urandom_range(0, 4), 1'b1, 10);
                end
                1: begin
                    // tiny periods: run into the entry limit
                    buffer_len = $urandom_range(600, 1200);
                    program_list(pick_base(), buffer_len, $urandom_range(1, 2),
                                 1'($urandom_range(0, 1)), 1'b1);
                    request_run(LIST_LIMIT + $urandom_range(0, 4), 1'b1, 0);
                end
                2: begin
                    buffer_len = $urandom_range(0, 1) ? '1 : LEN_W'($urandom);
                    program_list(pick_base(), buffer_len, pick_period(buffer_len),
                                 1'($urandom_range(0, 1)), 1'b1);
                    request_run($urandom_range(10, 40), 1'b1, 6);
                end
                3: begin
                    // reprogram mid-list and carry on without a restart
                    program_list(pick_base(), '0, pick_period(bdl_predictor.buffer_bytes),
                                 1'($urandom_range(0, 1)), 1'b0);
                    request_run($urandom_range(5, 30), 1'b0, 6);
                end
                default: begin
                    buffer_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100)
                                                             : $urandom_range(1, 20000);
                    program_list(pick_base(), buffer_len, pick_period(buffer_len),
                                 1'($urandom_range(0, 1)), 1'b1);
                    request_run($urandom_range(0, 40), 1'b1, 6);
                end
            endcase
            drain_list();
            phase++;
        end

        $display("Covered %0d requests over %0d random list setups: %0d entries checked,",
                 requests_sent, phase, bdl_predictor.entries_seen);
        $display("%0d interrupt marks, %0d list ends, %0d limit stops, %0d empty answers.",
                 bdl_predictor.ioc_seen, bdl_predictor.ends_seen,
                 bdl_predictor.limit_stops, bdl_predictor.empty_answers);
        if (bdl_predictor.mismatches == 0 && bdl_predictor.entries_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
